// File: sv/ibanchk_pkg.sv
// ibanchk_pkg: shared types, constants and mod-97 step tables for the IBAN checker.
// No dependencies; every other design file of the block refers to it by scoped names, the testbench imports it.
package ibanchk_pkg;

  // Field widths
  localparam int CHAR_W = 8;
  localparam int VAL_W  = 6;
  localparam int REM_W  = 7;
  localparam int CNT_W  = 6;
  localparam int PROD_W = 2 * REM_W;

  // Check constants
  localparam logic [REM_W-1:0] MODULUS    = 7'd97;
  localparam logic [CNT_W-1:0] LEN_MIN    = 6'd15;
  localparam logic [CNT_W-1:0] LEN_MAX    = 6'd34;
  localparam logic [CNT_W-1:0] PREFIX_LEN = 6'd4;
  localparam logic [CNT_W-1:0] COUNT_SAT  = 6'd35;

  // Decoupling queue between classifier and arithmetic
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character class
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DIGIT  = 2'd1,
    KIND_LETTER = 2'd2
  } kind_e;

  // Classified character as it travels through the queue
  typedef struct packed {
    kind_e             kind;
    logic [VAL_W-1:0]  value;
    logic              last;
  } item_t;

  // Table over all residues 0..96
  typedef logic [96:0][REM_W-1:0] rem_tbl_t;

  // Builds r -> (r * k) mod 97 by repeated addition of k mod 97
  function automatic rem_tbl_t build_step_tbl(input logic [REM_W-1:0] step);
    rem_tbl_t         tbl;
    logic [REM_W:0]   acc;
    tbl[0] = '0;
    for (int i = 1; i < 97; i++) begin
      acc = {1'b0, tbl[i-1]} + {1'b0, step};
      if (acc >= {1'b0, MODULUS}) begin
        acc = acc - {1'b0, MODULUS};
      end
      tbl[i] = acc[REM_W-1:0];
    end
    return tbl;
  endfunction

  // 10 mod 97, 100 mod 97 = 3, 128 mod 97 = 31
  localparam rem_tbl_t TIMES10_TBL  = build_step_tbl(7'd10);
  localparam rem_tbl_t TIMES100_TBL = build_step_tbl(7'd3);
  localparam rem_tbl_t TIMES128_TBL = build_step_tbl(7'd31);

  // One conditional subtract for values below twice the modulus
  function automatic logic [REM_W-1:0] reduce_once(input logic [REM_W:0] s);
    logic [REM_W:0] r;
    r = (s >= {1'b0, MODULUS}) ? s - {1'b0, MODULUS} : s;
    return r[REM_W-1:0];
  endfunction

endpackage

// File: sv/ibanchk_if.sv
// ibanchk_if: valid/ready channel interfaces for the IBAN checker.
// Depends on ibanchk_pkg for field widths.
interface ibanchk_char_if;
  logic                           valid;
  logic                           ready;
  logic [ibanchk_pkg::CHAR_W-1:0] char_code;
  logic                           last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface ibanchk_res_if;
  logic                          valid;
  logic                          ready;
  logic                          valid_res;
  logic                          length_bad;
  logic [ibanchk_pkg::REM_W-1:0] final_remainder;

  modport source (output valid, output valid_res, output length_bad,
                  output final_remainder, input ready);
  modport sink (input valid, input valid_res, input length_bad,
                input final_remainder, output ready);
endinterface

// File: sv/ibanchk_front.sv
// ibanchk_front: classifies incoming bytes as digit, letter or dropped.
// Depends on ibanchk_pkg and ibanchk_if; feeds ibanchk_queue.
module ibanchk_front (
  ibanchk_char_if.sink         char_i,
  output logic                 push_valid_o,
  output ibanchk_pkg::item_t   push_item_o,
  input  logic                 push_ready_i
);

  logic [ibanchk_pkg::CHAR_W-1:0] c;
  logic                           is_digit;
  logic                           is_letter;

  // Character class and value (A..Z and a..z share the low five bits)
  always_comb begin
    c         = char_i.char_code;
    is_digit  = (c >= 8'h30) && (c <= 8'h39);
    is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    push_item_o.last = char_i.last_char;
    if (is_digit) begin
      push_item_o.kind  = ibanchk_pkg::KIND_DIGIT;
      push_item_o.value = {2'b00, c[3:0]};
    end else if (is_letter) begin
      push_item_o.kind  = ibanchk_pkg::KIND_LETTER;
      push_item_o.value = {1'b0, c[4:0]} + 6'd9;
    end else begin
      push_item_o.kind  = ibanchk_pkg::KIND_NONE;
      push_item_o.value = '0;
    end
  end

  // Dropped bytes only matter when they close a candidate
  assign push_valid_o = char_i.valid && (is_digit || is_letter || char_i.last_char);
  assign char_i.ready = push_ready_i;

endmodule

// File: sv/ibanchk_queue.sv
// ibanchk_queue: small FIFO of classified characters between front and back.
// Depends on ibanchk_pkg.
module ibanchk_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  input  ibanchk_pkg::item_t  wr_item_i,
  output logic                wr_ready_o,
  output logic                rd_valid_o,
  output ibanchk_pkg::item_t  rd_item_o,
  input  logic                rd_ready_i
);

  ibanchk_pkg::item_t                  mem_q [ibanchk_pkg::QUEUE_DEPTH];
  logic [ibanchk_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [ibanchk_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [ibanchk_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                                push;
  logic                                pop;

  assign wr_ready_o = (cnt_q != ibanchk_pkg::QCNT_W'(ibanchk_pkg::QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == ibanchk_pkg::QPTR_W'(ibanchk_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == ibanchk_pkg::QPTR_W'(ibanchk_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// File: sv/ibanchk_back.sv
// ibanchk_back: mod-97 remainder update per character and the final rotation.
// Depends on ibanchk_pkg and ibanchk_if; pulls items from ibanchk_queue.
module ibanchk_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  ibanchk_pkg::item_t  item_i,
  output logic                item_ready_o,
  ibanchk_res_if.source       res_o
);

  localparam int REM_W  = ibanchk_pkg::REM_W;
  localparam int CNT_W  = ibanchk_pkg::CNT_W;
  localparam int PROD_W = ibanchk_pkg::PROD_W;

  // Running candidate state
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [REM_W-1:0]  body_q, body_d;
  logic [REM_W-1:0]  pre_q, pre_d;
  logic [REM_W-1:0]  pow_q, pow_d;

  // Finish pipeline: snapshot, product, output
  logic              fin_v_q, fin_v_d;
  logic [REM_W-1:0]  fin_body_q, fin_pow_q, fin_pre_q;
  logic              fin_bad_q;
  logic              prod_v_q, prod_v_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              prod_bad_q;
  logic              out_v_q, out_v_d;
  logic [REM_W-1:0]  out_rem_q, out_rem_d;
  logic              out_bad_q;

  logic              kept, letter, in_prefix, pop;
  logic              fin_load, prod_load, out_load;
  logic              fin_ready, prod_ready, out_ready;
  logic [REM_W-1:0]  rem_sel, scaled, rem_new, pow_new;
  logic [REM_W-1:0]  body_upd, pre_upd, pow_upd;
  logic [CNT_W-1:0]  cnt_upd;
  logic              bad_upd;
  logic [REM_W-1:0]  lo_red, hi_red;

  // Stage handshakes
  assign out_ready    = !out_v_q || res_o.ready;
  assign prod_ready   = !prod_v_q || out_ready;
  assign fin_ready    = !fin_v_q || prod_ready;
  assign item_ready_o = !(item_valid_i && item_i.last) || fin_ready;
  assign pop          = item_valid_i && item_ready_o;
  assign fin_load     = pop && item_i.last;
  assign prod_load    = fin_v_q && prod_ready;
  assign out_load     = prod_v_q && out_ready;

  // One shared remainder step: prefix while fewer than four kept, body after
  always_comb begin
    kept      = (item_i.kind != ibanchk_pkg::KIND_NONE);
    letter    = (item_i.kind == ibanchk_pkg::KIND_LETTER);
    in_prefix = (cnt_q < ibanchk_pkg::PREFIX_LEN);
    rem_sel   = in_prefix ? pre_q : body_q;
    scaled    = letter ? ibanchk_pkg::TIMES100_TBL[rem_sel] : ibanchk_pkg::TIMES10_TBL[rem_sel];
    rem_new   = ibanchk_pkg::reduce_once({1'b0, scaled} + {2'b00, item_i.value});
    pow_new   = letter ? ibanchk_pkg::TIMES100_TBL[pow_q] : ibanchk_pkg::TIMES10_TBL[pow_q];
    body_upd  = (kept && !in_prefix) ? rem_new : body_q;
    pre_upd   = (kept && in_prefix) ? rem_new : pre_q;
    pow_upd   = (kept && in_prefix) ? pow_new : pow_q;
    cnt_upd   = (kept && (cnt_q < ibanchk_pkg::COUNT_SAT)) ? cnt_q + 1'b1 : cnt_q;
    bad_upd   = (cnt_upd < ibanchk_pkg::LEN_MIN) || (cnt_upd > ibanchk_pkg::LEN_MAX);
  end

  // Next state: a closing character restarts the candidate
  always_comb begin
    cnt_d  = cnt_q;
    body_d = body_q;
    pre_d  = pre_q;
    pow_d  = pow_q;
    if (pop) begin
      if (item_i.last) begin
        cnt_d  = '0;
        body_d = '0;
        pre_d  = '0;
        pow_d  = REM_W'(1);
      end else begin
        cnt_d  = cnt_upd;
        body_d = body_upd;
        pre_d  = pre_upd;
        pow_d  = pow_upd;
      end
    end
  end

  // Valid flags of the finish pipeline
  always_comb begin
    fin_v_d  = fin_load ? 1'b1 : (prod_load ? 1'b0 : fin_v_q);
    prod_v_d = prod_load ? 1'b1 : (out_load ? 1'b0 : prod_v_q);
    out_v_d  = out_load ? 1'b1 : (res_o.ready ? 1'b0 : out_v_q);
  end

  // Rotation: body * 10^prefix_digits + prefix, then mod 97 split at bit 7
  always_comb begin
    prod_d    = (PROD_W'(fin_body_q) * PROD_W'(fin_pow_q)) + PROD_W'(fin_pre_q);
    lo_red    = ibanchk_pkg::reduce_once({1'b0, prod_q[REM_W-1:0]});
    hi_red    = ibanchk_pkg::TIMES128_TBL[prod_q[PROD_W-1:REM_W]];
    out_rem_d = ibanchk_pkg::reduce_once({1'b0, hi_red} + {1'b0, lo_red});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      body_q   <= '0;
      pre_q    <= '0;
      pow_q    <= REM_W'(1);
      fin_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      body_q   <= body_d;
      pre_q    <= pre_d;
      pow_q    <= pow_d;
      fin_v_q  <= fin_v_d;
      prod_v_q <= prod_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers of the finish pipeline
  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      fin_body_q <= body_upd;
      fin_pow_q  <= pow_upd;
      fin_pre_q  <= pre_upd;
      fin_bad_q  <= bad_upd;
    end
    if (prod_load) begin
      prod_q     <= prod_d;
      prod_bad_q <= fin_bad_q;
    end
    if (out_load) begin
      out_rem_q  <= out_rem_d;
      out_bad_q  <= prod_bad_q;
    end
  end

  assign res_o.valid           = out_v_q;
  assign res_o.final_remainder = out_rem_q;
  assign res_o.length_bad      = out_bad_q;
  assign res_o.valid_res       = !out_bad_q && (out_rem_q == REM_W'(1));

endmodule

// File: sv/iban_mod97_checker.sv
// iban_mod97_checker: top level of the streaming IBAN mod-97 check.
// Depends on ibanchk_pkg, ibanchk_if, ibanchk_front, ibanchk_queue, ibanchk_back.
//
// Takes one ASCII byte per cycle on char_i and, for each byte marked last_char,
// returns one transaction on res_o with valid_res, length_bad and the rotated
// remainder. Bytes other than 0-9, A-Z and a-z are skipped, lowercase counts as
// uppercase. Sustained rate is one byte per cycle: each kept character costs a
// single table lookup plus one conditional subtract of 97 in the back end, and
// the final rotation runs in a three-register finish pipeline that overlaps the
// next candidate. Input stalls only when res_o has been held off long enough
// to fill the finish pipeline and the two-entry queue behind the classifier.
module iban_mod97_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  ibanchk_char_if.sink  char_i,
  ibanchk_res_if.source res_o
);

  logic                push_valid;
  logic                push_ready;
  ibanchk_pkg::item_t  push_item;
  logic                pop_valid;
  logic                pop_ready;
  ibanchk_pkg::item_t  pop_item;

  // Classifier
  ibanchk_front u_front (
    .char_i       (char_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  // Decoupling queue
  ibanchk_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_item_i  (push_item),
    .wr_ready_o (push_ready),
    .rd_valid_o (pop_valid),
    .rd_item_o  (pop_item),
    .rd_ready_i (pop_ready)
  );

  // Arithmetic and result
  ibanchk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .item_ready_o (pop_ready),
    .res_o        (res_o)
  );

`ifndef SYNTHESIS
  // A passing check always reports remainder one
  a_pass_rem_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.valid_res) |-> (res_o.final_remainder == 7'd1))
    else $error("valid_res set with remainder other than one");

  // A passing check never carries a length error
  a_pass_len_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.valid_res && res_o.length_bad))
    else $error("valid_res set together with length_bad");

  // Reported remainder is fully reduced
  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.final_remainder < 7'd97))
    else $error("final_remainder not reduced modulo 97");

  // Queue only hands over classified characters or candidate closers
  a_queue_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid |-> ((pop_item.kind != ibanchk_pkg::KIND_NONE) || pop_item.last))
    else $error("dropped byte reached the back end");
`endif

endmodule

// File: test/tb_iban_mod97_checker.sv
`timescale 1ns / 100ps
// tb_iban_mod97_checker: self-checking testbench for the streaming IBAN mod-97 checker.
// Depends on ibanchk_pkg, ibanchk_if and iban_mod97_checker; a directed table first,
// then random candidates; untyped rows are checked by an in-bench mod-97 predictor.
module tb_iban_mod97_checker;
  import ibanchk_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RST_CYCLES   = 6;
  localparam int TARGET_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_GAP      = 20;
  localparam int NUM_DIR      = 25;

  typedef struct packed {
    logic             valid_res;
    logic             length_bad;
    logic [REM_W-1:0] final_remainder;
  } check_res_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              typed;
    check_res_t        res;
  } char_row_t;

  logic clk_i;
  logic rst_ni;

  ibanchk_char_if char_if ();
  ibanchk_res_if  res_if ();

  iban_mod97_checker DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .res_o  (res_if)
  );

  // Predictor state for the candidate in flight
  logic [CNT_W-1:0] mdl_count  = '0;
  logic [REM_W-1:0] mdl_body   = '0;
  logic [REM_W-1:0] mdl_prefix = '0;
  logic [REM_W-1:0] mdl_power  = 7'd1;

  check_res_t     expected_q[$];
  logic [7:0]     cand[$];
  int             err_count   = 0;
  int             items_sent  = 0;
  int             cycle_count = 0;
  int             tx_idle_pct = 18;
  int             rx_idle_pct = 50;
  bit             burst_phase = 1'b0;

  // Directed rows: boundaries, lower/upper case, separators, a known good IBAN
  char_row_t dir_tbl [NUM_DIR] = '{
    '{8'h00, 1'b1, 1'b1, '{1'b0, 1'b1, 7'd0}},
    '{8'hFF, 1'b1, 1'b1, '{1'b0, 1'b1, 7'd0}},
    '{"9",   1'b1, 1'b1, '{1'b0, 1'b1, 7'd9}},
    '{"z",   1'b1, 1'b1, '{1'b0, 1'b1, 7'd35}},
    '{"0",   1'b0, 1'b0, '0},
    '{"A",   1'b1, 1'b0, '0},
    '{"n",   1'b0, 1'b0, '0},
    '{"o",   1'b0, 1'b0, '0},
    '{"9",   1'b0, 1'b0, '0},
    '{"3",   1'b0, 1'b0, '0},
    '{" ",   1'b0, 1'b0, '0},
    '{"8",   1'b0, 1'b0, '0},
    '{"6",   1'b0, 1'b0, '0},
    '{"0",   1'b0, 1'b0, '0},
    '{"1",   1'b0, 1'b0, '0},
    '{"-",   1'b0, 1'b0, '0},
    '{"1",   1'b0, 1'b0, '0},
    '{"1",   1'b0, 1'b0, '0},
    '{"1",   1'b0, 1'b0, '0},
    '{"7",   1'b0, 1'b0, '0},
    '{"9",   1'b0, 1'b0, '0},
    '{"4",   1'b0, 1'b0, '0},
    '{"7",   1'b1, 1'b0, '0},
    '{"@",   1'b0, 1'b0, '0},
    '{"{",   1'b1, 1'b1, '{1'b0, 1'b1, 7'd0}}
  };

  // Character class and its value 0..35
  function automatic kind_e classify_char(input logic [7:0] c, output logic [VAL_W-1:0] val);
    kind_e k;
    k   = KIND_NONE;
    val = '0;
    if (c >= "0" && c <= "9") begin
      k   = KIND_DIGIT;
      val = VAL_W'(c - "0");
    end else if (c >= "A" && c <= "Z") begin
      k   = KIND_LETTER;
      val = VAL_W'(c - "A" + 10);
    end else if (c >= "a" && c <= "z") begin
      k   = KIND_LETTER;
      val = VAL_W'(c - "a" + 10);
    end
    return k;
  endfunction

  // Advances the checker state by one byte; returns 1 with the result on a last byte
  function automatic bit mod97_step(input logic [7:0] c, input logic last,
                                    output check_res_t r);
    logic [VAL_W-1:0] v;
    kind_e            k;
    int               m;
    int               scale;
    int               fin;
    bit               bad;
    m = int'(MODULUS);
    r = '0;
    k = classify_char(c, v);
    if (k != KIND_NONE) begin
      scale = (k == KIND_DIGIT) ? 10 : 100;
      if (mdl_count < PREFIX_LEN) begin
        mdl_prefix = REM_W'((int'(mdl_prefix) * scale + int'(v)) % m);
        mdl_power  = REM_W'((int'(mdl_power) * scale) % m);
      end else begin
        mdl_body = REM_W'((int'(mdl_body) * scale + int'(v)) % m);
      end
      if (mdl_count < COUNT_SAT) mdl_count = mdl_count + 1'b1;
    end
    if (!last) return 1'b0;
    // rotate the prefix behind the body
    fin = (int'(mdl_body) * int'(mdl_power) + int'(mdl_prefix)) % m;
    bad = (mdl_count < LEN_MIN) || (mdl_count > LEN_MAX);
    r.valid_res       = !bad && (fin == 1);
    r.length_bad      = bad;
    r.final_remainder = REM_W'(fin);
    mdl_count  = '0;
    mdl_body   = '0;
    mdl_prefix = '0;
    mdl_power  = 7'd1;
    return 1'b1;
  endfunction

  // Plain mod-97 of an alphanumeric string, used to build check digits
  function automatic int text_mod97(input logic [7:0] t[$]);
    logic [VAL_W-1:0] v;
    kind_e            k;
    int               r;
    r = 0;
    foreach (t[i]) begin
      k = classify_char(t[i], v);
      if (k == KIND_DIGIT) r = (r * 10 + int'(v)) % int'(MODULUS);
      else if (k == KIND_LETTER) r = (r * 100 + int'(v)) % int'(MODULUS);
    end
    return r;
  endfunction

  function automatic logic [7:0] alnum_char(input int v);
    return (v < 10) ? 8'("0" + v) : 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] random_sep();
    logic [7:0]       b;
    logic [VAL_W-1:0] v;
    do b = 8'($urandom_range(0, 255));
    while (classify_char(b, v) != KIND_NONE);
    return b;
  endfunction

  // Builds the byte stream of one candidate into cand
  task automatic build_candidate();
    int               pick;
    int               len;
    int               chk;
    logic [7:0]       seq[$];
    logic [7:0]       rot[$];
    logic [7:0]       c0;
    logic [7:0]       c1;
    logic [7:0]       b;
    logic [VAL_W-1:0] v;
    cand.delete();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // well-formed IBAN with correct check digits, some later corrupted
      len = (pick < 10) ? $urandom_range(15, 34) : $urandom_range(15, 22);
      c0  = 8'("A" + $urandom_range(0, 25));
      c1  = 8'("A" + $urandom_range(0, 25));
      for (int i = 0; i < len - 4; i++) seq.push_back(alnum_char($urandom_range(0, 35)));
      rot = seq;
      rot.push_back(c0);
      rot.push_back(c1);
      rot.push_back("0");
      rot.push_back("0");
      chk = 98 - text_mod97(rot);
      seq.push_front(8'("0" + chk % 10));
      seq.push_front(8'("0" + chk / 10));
      seq.push_front(c1);
      seq.push_front(c0);
      if (pick >= 55) seq[$urandom_range(0, len - 1)] = alnum_char($urandom_range(0, 35));
    end else if (pick < 85) begin
      // arbitrary alphanumeric length, covers short and saturated counts
      len = $urandom_range(0, 40);
      for (int i = 0; i < len; i++) seq.push_back(alnum_char($urandom_range(0, 35)));
    end else begin
      // raw bytes over the whole code range
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) seq.push_back(8'($urandom_range(0, 255)));
    end
    // lowercase folding and separators between characters
    foreach (seq[i]) begin
      b = seq[i];
      if (classify_char(b, v) == KIND_LETTER && $urandom_range(0, 99) < 30) b = b | 8'h20;
      if ($urandom_range(0, 99) < 10) cand.push_back(random_sep());
      cand.push_back(b);
    end
    if (cand.size() == 0) cand.push_back(random_sep());
  endtask

  // Offers one byte, waits for the transaction, updates the predictor
  task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
                           input check_res_t typed_res);
    int               gap;
    check_res_t       r;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= c;
    char_if.last_char <= last;
    do @(posedge clk_i);
    while (!char_if.ready);
    items_sent++;
    if (mod97_step(c, last, r)) expected_q.push_back(typed ? typed_res : r);
  endtask

  // Stops sending until every expected result has come back
  task automatic wait_drained();
    char_if.valid <= 1'b0;
    do @(posedge clk_i);
    while (expected_q.size() != 0);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Run watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Result receiver: random back-pressure plus one long hold-off
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (burst_phase && !held) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin : result_check
    check_res_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with no result expected");
        err_count++;
      end else begin
        e = expected_q.pop_front();
        if (res_if.valid_res !== e.valid_res) begin
          $error("valid_res: expected %0d, got %0d", e.valid_res, res_if.valid_res);
          err_count++;
        end
        if (res_if.length_bad !== e.length_bad) begin
          $error("length_bad: expected %0d, got %0d", e.length_bad, res_if.length_bad);
          err_count++;
        end
        if (res_if.final_remainder !== e.final_remainder) begin
          $error("final_remainder: expected %0d, got %0d", e.final_remainder,
                 res_if.final_remainder);
          err_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int phase;
    phase = 0;
    rst_ni            <= 1'b0;
    char_if.valid     <= 1'b0;
    char_if.char_code <= '0;
    char_if.last_char <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) send_char(dir_tbl[i].code, dir_tbl[i].last, dir_tbl[i].typed,
                                   dir_tbl[i].res);

    while (items_sent < TARGET_ITEMS) begin
      if (phase == 0 && items_sent >= TARGET_ITEMS / 3) begin
        phase       = 1;
        tx_idle_pct = 50;
        rx_idle_pct = 18;
      end else if (phase == 1 && items_sent >= 2 * TARGET_ITEMS / 3) begin
        // drain, then stream flat out into a stalled receiver
        wait_drained();
        phase       = 2;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        burst_phase = 1'b1;
      end
      build_candidate();
      foreach (cand[i]) send_char(cand[i], i == cand.size() - 1, 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/ibanchk_pkg.sv
sv/ibanchk_if.sv
sv/ibanchk_front.sv
sv/ibanchk_queue.sv
sv/ibanchk_back.sv
sv/iban_mod97_checker.sv
test/tb_iban_mod97_checker.sv
